// File: hw/rtl/sns_pkg.sv
// ----------------------------------------------------------------------------
// sns_pkg: shared types and constants
// Item and result structs, the result batch passed to the output buffer, and
// the NAL type rules used by the filter.
// ----------------------------------------------------------------------------
package sns_pkg;

  localparam int WIN_DEPTH   = 4;
  localparam int MAX_RESULTS = WIN_DEPTH + 1;
  localparam int FILL_W      = 3;
  localparam int CNT_W       = 3;

  localparam logic [7:0] TYPE_MASK   = 8'h1f;
  localparam logic [4:0] VCL_TYPE_MAX = 5'd5;
  localparam logic [4:0] NAL_SPS     = 5'd7;
  localparam logic [4:0] NAL_PPS     = 5'd8;
  localparam logic [4:0] NAL_AUD     = 5'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
    logic       apply_filter;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_frame;
  } out_item_t;

  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] slot;
    logic [CNT_W-1:0]            count;
  } batch_t;

  function automatic logic type_kept(input logic [4:0] t);
    return (t <= VCL_TYPE_MAX) || (t == NAL_SPS) || (t == NAL_PPS) || (t == NAL_AUD);
  endfunction

endpackage

// File: hw/rtl/sns_filter.sv
// ----------------------------------------------------------------------------
// sns_filter: look-behind window and region decision
// Holds the four-byte window and frame state, and forms the batch of results
// caused by one byte: the byte leaving the window plus the flush at frame end, or a bare end marker.
// ----------------------------------------------------------------------------
module sns_filter (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  sns_pkg::in_item_t item,
  output sns_pkg::batch_t   batch
);
  import sns_pkg::*;

  logic [7:0]        look_behind [WIN_DEPTH];
  logic [FILL_W-1:0] window_fill;
  logic              region_kept;
  logic              vcl_seen;
  logic              frame_filtering;
  logic              mid_frame;

  logic [7:0]        look_behind_next [WIN_DEPTH];
  logic [FILL_W-1:0] window_fill_next;
  logic              region_kept_next;
  logic              vcl_seen_next;
  logic              frame_filtering_next;
  logic              mid_frame_next;

  always_comb begin
    logic [7:0]        lb [WIN_DEPTH];
    logic [FILL_W-1:0] fill;
    logic              rk;
    logic              vs;
    logic [7:0]        cand [MAX_RESULTS];
    logic              lead;
    logic [4:0]        type_code;
    logic [CNT_W-1:0]  cnt;

    // open a new frame when none is in progress
    for (int i = 0; i < WIN_DEPTH; i++) begin
      lb[i] = mid_frame ? look_behind[i] : 8'h00;
    end
    fill = mid_frame ? window_fill : '0;
    rk   = mid_frame ? region_kept : !item.apply_filter;
    vs   = mid_frame ? vcl_seen    : !item.apply_filter;
    frame_filtering_next = mid_frame ? frame_filtering : item.apply_filter;

    type_code = 5'(item.data_byte & TYPE_MASK);
    lead      = 1'b0;
    cand[0]   = lb[0];

    if (fill >= FILL_W'(WIN_DEPTH)) begin
      if (!vs && lb[0] == 8'h00 && lb[1] == 8'h00 && lb[2] == 8'h00 && lb[3] == 8'h01) begin
        rk = type_kept(type_code);
        if (type_code <= VCL_TYPE_MAX) begin
          vs = 1'b1;
        end
      end
      lead = rk;
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        lb[i] = lb[i+1];
      end
      lb[WIN_DEPTH-1] = item.data_byte;
      fill = FILL_W'(WIN_DEPTH);
    end else begin
      lb[fill[1:0]] = item.data_byte;
      fill = fill + 1'b1;
    end

    for (int i = 0; i < WIN_DEPTH; i++) begin
      cand[i+1] = lb[i];
    end

    // leaving byte first, then the flushed window
    cnt = CNT_W'(lead);
    if (item.frame_end && rk) begin
      cnt = cnt + CNT_W'(fill);
    end
    for (int k = 0; k < MAX_RESULTS - 1; k++) begin
      batch.slot[k].out_byte = lead ? cand[k] : cand[k+1];
      batch.slot[k].byte_valid = 1'b1;
    end
    batch.slot[MAX_RESULTS-1].out_byte   = cand[MAX_RESULTS-1];
    batch.slot[MAX_RESULTS-1].byte_valid = 1'b1;

    // bare end marker when the frame gave nothing
    if (item.frame_end && cnt == '0) begin
      batch.slot[0].out_byte   = 8'h00;
      batch.slot[0].byte_valid = 1'b0;
      cnt = CNT_W'(1);
    end
    for (int k = 0; k < MAX_RESULTS; k++) begin
      batch.slot[k].end_of_frame = item.frame_end && (CNT_W'(k) == cnt - 1'b1);
    end
    batch.count = cnt;

    region_kept_next = rk;
    vcl_seen_next    = vs;
    if (item.frame_end) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        look_behind_next[i] = 8'h00;
      end
      window_fill_next = '0;
      mid_frame_next   = 1'b0;
    end else begin
      look_behind_next = lb;
      window_fill_next = fill;
      mid_frame_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        look_behind[i] <= 8'h00;
      end
      window_fill     <= '0;
      region_kept     <= 1'b0;
      vcl_seen        <= 1'b0;
      frame_filtering <= 1'b0;
      mid_frame       <= 1'b0;
    end else if (step) begin
      look_behind     <= look_behind_next;
      window_fill     <= window_fill_next;
      region_kept     <= region_kept_next;
      vcl_seen        <= vcl_seen_next;
      frame_filtering <= frame_filtering_next;
      mid_frame       <= mid_frame_next;
    end
  end

  a_unfiltered_passes: assert property (@(posedge clk) disable iff (rst)
    (mid_frame && !frame_filtering) |-> (vcl_seen && region_kept))
    else $error("unfiltered frame lost pass-through state");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    window_fill <= FILL_W'(WIN_DEPTH))
    else $error("window fill out of range");

  a_frame_close: assert property (@(posedge clk) disable iff (rst)
    (step && item.frame_end) |=> (!mid_frame && window_fill == '0))
    else $error("frame end did not close the frame");

endmodule

// File: hw/rtl/sns_out_buf.sv
// ----------------------------------------------------------------------------
// sns_out_buf: result buffer
// Takes a batch of up to five results and gives them out one per request.
// ----------------------------------------------------------------------------
module sns_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  sns_pkg::batch_t    batch,
  output logic               can_load,
  output logic               result_valid,
  input  logic               result_ready,
  output sns_pkg::out_item_t result
);
  import sns_pkg::*;

  out_item_t        entry [MAX_RESULTS];
  logic [CNT_W-1:0] cnt;
  logic             pop;

  assign result_valid = (cnt != '0);
  assign result       = entry[0];
  assign pop          = result_valid && result_ready;
  assign can_load     = (cnt == '0) || (cnt == CNT_W'(1) && result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= batch.count;
    end else if (pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  // advance the queue head on each request
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
        entry[k] <= batch.slot[k];
      end
    end else if (pop) begin
      for (int k = 0; k < MAX_RESULTS - 1; k++) begin
        entry[k] <= entry[k+1];
      end
    end
  end

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !load) |=> (cnt == $past(cnt) - 1'b1))
    else $error("result count did not drop after a request");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.end_of_frame) |-> (cnt == CNT_W'(1)))
    else $error("end of frame not on the last queued result");

endmodule

// File: hw/rtl/h264_sei_nal_stripper_core.sv
// ----------------------------------------------------------------------------
// h264_sei_nal_stripper_core: Annex B NAL unit filter, top level
// A byte leaves the window four bytes later and reaches the result port after
//   the byte pushing it out passes the hold register into the output buffer.
// Throughput: one byte per cycle while the buffer can load; a frame-end byte
//   yields up to five results, sent one per cycle through the single result
//   port when ready. Reset clears all control state at once; no clearing pass.
// ----------------------------------------------------------------------------
module h264_sei_nal_stripper_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  sns_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output sns_pkg::out_item_t result
);
  import sns_pkg::*;

  in_item_t hold;
  logic     hold_full;
  logic     can_load;
  logic     load;
  batch_t   batch;

  assign load       = hold_full && can_load;
  assign item_ready = !hold_full || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_full <= 1'b0;
    end else if (item_valid && item_ready) begin
      hold_full <= 1'b1;
    end else if (load) begin
      hold_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      hold <= item;
    end
  end

  sns_filter u_filter (
    .clk   (clk),
    .rst   (rst),
    .step  (load),
    .item  (hold),
    .batch (batch)
  );

  sns_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .batch        (batch),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
